// File: hw/rtl/olv_pkg.sv
package olv_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned FIELD_W  = 4;
	localparam int unsigned PART_W   = 3;
	localparam int unsigned DOT_W    = 2;
	localparam int unsigned VERD_W   = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [1:0] POS_START  = 2'd0;
	localparam logic [1:0] POS_LETTER = 2'd1;
	localparam logic [1:0] POS_BODY   = 2'd2;

	localparam logic [1:0] KIND_OTHER  = 2'd0;
	localparam logic [1:0] KIND_FACE   = 2'd1;
	localparam logic [1:0] KIND_VERTEX = 2'd2;

	localparam logic [VERD_W-1:0] VERD_OK        = 2'd0;
	localparam logic [VERD_W-1:0] VERD_MALFORMED = 2'd1;
	localparam logic [VERD_W-1:0] VERD_NO_VERTEX = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX_PARTS = 1'd1;

	localparam logic [FIELD_W-1:0] MAX_FIELDS_RST = 4'd4;
	localparam logic [PART_W-1:0]  MAX_PARTS_RST  = 3'd3;
	localparam logic [FIELD_W-1:0] FIELD_CAP      = 4'd15;
	localparam logic [PART_W-1:0]  PART_CAP       = 3'd7;
	localparam logic [DOT_W-1:0]   DOT_CAP        = 2'd2;

	localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
	localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
	localparam logic [DATA_W-1:0] CH_VT    = 8'h0B;
	localparam logic [DATA_W-1:0] CH_FF    = 8'h0C;
	localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
	localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
	localparam logic [DATA_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [DATA_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [DATA_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
	localparam logic [DATA_W-1:0] CH_F     = 8'h66;
	localparam logic [DATA_W-1:0] CH_V     = 8'h76;

	typedef struct packed {
		logic [1:0]         pos;
		logic [1:0]         kind;
		logic               in_tok;
		logic [FIELD_W-1:0] field_cnt;
		logic [DOT_W-1:0]   dot_cnt;
		logic [PART_W-1:0]  piece_cnt;
		logic               after_slash;
		logic               err;
		logic               vtx_seen;
	} olv_state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] max_fields;
		logic [PART_W-1:0]  max_parts;
	} olv_cfg_t;

	localparam olv_state_t STATE_RST = '{
		pos:         POS_START,
		kind:        KIND_OTHER,
		in_tok:      1'b0,
		field_cnt:   '0,
		dot_cnt:     '0,
		piece_cnt:   '0,
		after_slash: 1'b1,
		err:         1'b0,
		vtx_seen:    1'b0
	};

endpackage

// File: hw/rtl/obj_text_line_validator_top.sv
// The last byte of a file is held in the input register; its verdict is then
// registered in the result register, from which m_axis takes it.
// Throughput: one byte per cycle; only a byte with tlast waits, and only
// while an earlier verdict sits unaccepted in the result register.
// Only a byte with tlast yields a verdict; the file state then clears.
// arst_n low clears the line and file state and the valid flags of both registers, and sets the limits to 4 and 3.
module obj_text_line_validator_top
	import olv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,   // end_of_file
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [1:0] verdict, [7:2] zero
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	olv_cfg_t           cfg;
	olv_state_t         st_q;
	olv_state_t         st_nxt;
	logic [VERD_W-1:0]  verdict;
	logic               valid_s1;
	logic [DATA_W-1:0]  byte_s1;
	logic               last_s1;
	logic               adv;
	logic               out_valid_q;
	logic [VERD_W-1:0]  verdict_q;

	assign cfg_ready = 1'b1;

	olv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	olv_step u_step (
		.cur     (st_q),
		.cfg     (cfg),
		.c       (byte_s1),
		.last    (last_s1),
		.nxt     (st_nxt),
		.verdict (verdict)
	);

	// a byte without tlast never needs the result slot
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8 - VERD_W){1'b0}}, verdict_q};

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q == STATE_RST)
		else $error("file state not cleared after last byte");

	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> out_valid_q)
		else $error("last byte gave no verdict");

	a_err_latched: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err && !(adv && last_s1) |=> st_q.err)
		else $error("error flag dropped before end of file");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (verdict_q == VERD_OK || verdict_q == VERD_MALFORMED ||
			verdict_q == VERD_NO_VERTEX))
		else $error("verdict code out of range");

endmodule

// File: hw/rtl/olv_cfg.sv
module olv_cfg
	import olv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output olv_cfg_t              cfg
);

	logic [FIELD_W-1:0] max_fields_q;
	logic [PART_W-1:0]  max_parts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= MAX_FIELDS_RST;
			max_parts_q  <= MAX_PARTS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_FIELDS:      max_fields_q <= wr_data[FIELD_W-1:0];
				REG_MAX_INDEX_PARTS: max_parts_q  <= wr_data[PART_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.max_fields = max_fields_q;
	assign cfg.max_parts  = max_parts_q;

endmodule

// File: hw/rtl/olv_step.sv
module olv_step
	import olv_pkg::*;
(
	input  olv_state_t         cur,
	input  olv_cfg_t           cfg,
	input  logic [DATA_W-1:0]  c,
	input  logic               last,
	output olv_state_t         nxt,
	output logic [VERD_W-1:0]  verdict
);

	logic       is_space;
	logic       is_num;
	olv_state_t n;

	assign is_space = c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	assign is_num   = (c inside {[CH_ZERO:CH_NINE]}) || (c == CH_MINUS);

	always_comb begin
		n = cur;
		if (c == CH_LF) begin
			n.pos    = POS_START;
			n.kind   = KIND_OTHER;
			n.in_tok = 1'b0;
		end else begin
			case (cur.pos)
				POS_START: begin
					n.pos = POS_LETTER;
					if (c == CH_F) begin
						n.kind = KIND_FACE;
					end else if (c == CH_V) begin
						n.kind = KIND_VERTEX;
					end else begin
						n.kind = KIND_OTHER;
						n.pos  = POS_BODY;
					end
				end
				POS_LETTER: begin
					n.pos = POS_BODY;
					if (c == CH_SPACE) begin
						n.in_tok    = 1'b0;
						n.field_cnt = '0;
						if (cur.kind == KIND_VERTEX) begin
							n.vtx_seen = 1'b1;
						end
					end else begin
						n.kind = KIND_OTHER;
					end
				end
				POS_BODY: begin
					if (cur.kind == KIND_FACE || cur.kind == KIND_VERTEX) begin
						if (is_space) begin
							n.in_tok = 1'b0;
						end else begin
							// token start
							if (!cur.in_tok) begin
								n.in_tok      = 1'b1;
								n.dot_cnt     = '0;
								n.piece_cnt   = '0;
								n.after_slash = 1'b1;
								if (cur.field_cnt >= cfg.max_fields) begin
									n.err = 1'b1;
								end
								if (cur.field_cnt != FIELD_CAP) begin
									n.field_cnt = cur.field_cnt + 1'b1;
								end
							end
							if (cur.kind == KIND_FACE) begin
								if (c == CH_SLASH) begin
									n.after_slash = 1'b1;
								end else if (is_num) begin
									if (n.after_slash) begin
										n.after_slash = 1'b0;
										if (n.piece_cnt >= cfg.max_parts) begin
											n.err = 1'b1;
										end
										if (n.piece_cnt != PART_CAP) begin
											n.piece_cnt = n.piece_cnt + 1'b1;
										end
									end
								end else begin
									n.err = 1'b1;
								end
							end else begin
								if (c == CH_DOT) begin
									if (n.dot_cnt != '0) begin
										n.err = 1'b1;
									end
									if (n.dot_cnt != DOT_CAP) begin
										n.dot_cnt = n.dot_cnt + 1'b1;
									end
								end else if (!is_num) begin
									n.err = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (n.err) begin
			verdict = VERD_MALFORMED;
		end else if (!n.vtx_seen) begin
			verdict = VERD_NO_VERTEX;
		end else begin
			verdict = VERD_OK;
		end
	end

	assign nxt = last ? STATE_RST : n;

endmodule
